// ----- hw/rtl/wsd_pkg.sv -----
// Shared types and constants for the windowed spike detector.
// No dependencies.
`default_nettype none
package wsd_pkg;
    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned SUM_W = 40;
    localparam int unsigned SQ_W = 64;
    localparam int unsigned CNT_W = 16;
    localparam int unsigned MIN_SAMPLES = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    typedef enum logic [0:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_SPIKE_MULT    = 1'b1
    } cfg_index_t;
endpackage
`default_nettype wire

// ----- hw/rtl/wsd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module wsd_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/windowed_spike_detector_unit.sv -----
// Windowed spike detector: one sample per word, ring window in a RAM, sums,
// serial divider and serial square root. Uses wsd_pkg and wsd_ram.
// Flow, accept to result valid: an invalid word goes straight to output; a valid
//   word with fewer than five samples is added and output; otherwise a mean divide,
//   a variance divide, a square root and setup/output, after any oldest-sample drops.
// Throughput: one word in flight; the next word is taken the cycle after its
//   result is registered. A stalled result only holds the engine when the next
//   result is ready. Reset (rst_n low, async) empties the window, clears counters
//   and restores window_length 64, spike_multiplier 768.
`default_nettype none
module windowed_spike_detector_unit #(
    parameter int unsigned WINDOW_MAX = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [23:0] sample_value,
    input  wire logic        sample_invalid,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [23:0]      window_mean,
    output logic [23:0]      window_deviation,
    output logic             spike_seen,
    output logic             stats_valid,
    output logic [15:0]      spike_total,
    output logic [15:0]      invalid_total,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    import wsd_pkg::*;

    localparam int unsigned AW = $clog2(WINDOW_MAX);
    localparam int unsigned LW = $clog2(WINDOW_MAX + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DROP_RD, S_DROP_SUB, S_ADD, S_MEAN, S_VAR_PREP,
        S_VAR_PREP2, S_VAR_DIV, S_VAR_FIX, S_SQRT, S_SPIKE, S_SPIKE2, S_OUT
    } state_t;

    state_t                 state_reg;
    logic [6:0]             wlen_reg;
    logic [15:0]            mult_reg;
    logic [AW-1:0]          slot_reg;
    logic [LW-1:0]          fill_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [CNT_W-1:0]       spike_cnt_reg;
    logic [CNT_W-1:0]       inv_cnt_reg;
    logic [SAMPLE_W-1:0]    x_reg;
    logic [6:0]             step_reg;
    // shared divider: dividend shifts in, remainder accumulates
    logic [SQ_W-1:0]        dq_reg;
    logic [SQ_W-1:0]        drem_reg;
    logic [SUM_W-1:0]       mean_reg;
    logic [SUM_W-1:0]       r_reg;
    logic [SQ_W-1:0]        a_reg;
    logic [SQ_W-1:0]        t_reg;
    logic [SQ_W-1:0]        var_reg;
    logic [SQ_W-1:0]        sqrem_reg;
    logic [31:0]            root_reg;
    logic [SQ_W-1:0]        prod_reg;
    logic                   stats_flag_reg;
    logic                   spike_flag_reg;
    logic                   out_valid_reg;
    logic [23:0]            o_mean_reg;
    logic [23:0]            o_dev_reg;
    logic                   o_spike_reg;
    logic                   o_stats_reg;
    logic [CNT_W-1:0]       o_spikes_reg;
    logic [CNT_W-1:0]       o_invalids_reg;

    logic [LW-1:0]          len_eff;
    logic [AW-1:0]          old_addr;
    logic [SAMPLE_W-1:0]    rdata;
    logic                   ram_we;
    logic                   accept;
    logic                   out_free;
    logic [SQ_W-1:0]        div_trial;
    logic [SQ_W-1:0]        nwide;
    logic [SQ_W+1:0]        sq_trial;
    logic [SQ_W+1:0]        sq_rem_sh;

    always_comb
    begin
        if (wlen_reg == 7'd0)
        begin
            len_eff = LW'(1);
        end
        else if (32'(wlen_reg) > WINDOW_MAX)
        begin
            len_eff = LW'(WINDOW_MAX);
        end
        else
        begin
            len_eff = LW'(wlen_reg);
        end
    end

    // oldest entry: slot - fill modulo depth
    always_comb
    begin
        if (32'(slot_reg) >= 32'(fill_reg))
        begin
            old_addr = AW'(32'(slot_reg) - 32'(fill_reg));
        end
        else
        begin
            old_addr = AW'(32'(slot_reg) + WINDOW_MAX - 32'(fill_reg));
        end
    end

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign ram_we   = (state_reg == S_ADD);
    assign nwide    = SQ_W'(fill_reg);
    assign div_trial = {drem_reg[SQ_W-2:0], dq_reg[SQ_W-1]};
    // restoring sqrt: two bits of the radicand per step
    assign sq_rem_sh = {sqrem_reg, var_reg[SQ_W-1:SQ_W-2]};
    assign sq_trial  = {root_reg, 2'b01};

    wsd_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (x_reg),
        .raddr (old_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wlen_reg      <= 7'd64;
            mult_reg      <= 16'd768;
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            spike_cnt_reg <= '0;
            inv_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_WINDOW_LENGTH: wlen_reg <= cfg_data[6:0];
                    CFG_SPIKE_MULT:    mult_reg <= cfg_data;
                    default:           wlen_reg <= wlen_reg;
                endcase
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg <= sample_value;
                        stats_flag_reg <= 1'b0;
                        spike_flag_reg <= 1'b0;
                        if (sample_invalid)
                        begin
                            if (inv_cnt_reg != CNT_MAX)
                            begin
                                inv_cnt_reg <= inv_cnt_reg + 1'b1;
                            end
                            state_reg <= S_OUT;
                        end
                        else if (fill_reg >= len_eff)
                        begin
                            state_reg <= S_DROP_RD;
                        end
                        else
                        begin
                            state_reg <= S_ADD;
                        end
                    end
                end
                S_DROP_RD:
                begin
                    state_reg <= S_DROP_SUB; // RAM read in flight
                    prod_reg  <= '0;
                end
                S_DROP_SUB:
                begin
                    sum_reg  <= sum_reg - SUM_W'(rdata);
                    sq_reg   <= sq_reg - SQ_W'(rdata) * SQ_W'(rdata);
                    fill_reg <= fill_reg - 1'b1;
                    state_reg <= (fill_reg - 1'b1 >= len_eff) ? S_DROP_RD : S_ADD;
                end
                S_ADD:
                begin
                    slot_reg <= (32'(slot_reg) == WINDOW_MAX - 1) ? '0
                                                                   : AW'(32'(slot_reg) + 1);
                    fill_reg <= fill_reg + 1'b1;
                    sum_reg  <= sum_reg + SUM_W'(x_reg);
                    sq_reg   <= sq_reg + SQ_W'(x_reg) * SQ_W'(x_reg);
                    if (32'(fill_reg) + 1 >= MIN_SAMPLES)
                    begin
                        dq_reg    <= SQ_W'(sum_reg + SUM_W'(x_reg));
                        drem_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_MEAN;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_MEAN, S_VAR_DIV:
                begin
                    if (div_trial >= nwide)
                    begin
                        drem_reg <= div_trial - nwide;
                        dq_reg   <= {dq_reg[SQ_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= div_trial;
                        dq_reg   <= {dq_reg[SQ_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 7'(SQ_W - 1))
                    begin
                        state_reg <= (state_reg == S_MEAN) ? S_VAR_PREP : S_VAR_FIX;
                    end
                end
                S_VAR_PREP:
                begin
                    mean_reg <= SUM_W'(dq_reg);
                    // r = S - n*m ; n*m registered in prod, fits 32 bits
                    prod_reg <= SQ_W'(dq_reg[31:0] * 32'(fill_reg));
                    state_reg <= S_VAR_PREP2;
                    step_reg <= '0;
                end
                S_VAR_PREP2:
                begin
                    // step 0: r and t=n*m*m; step 1: a=m*r; step 2: a = sq - t - 2a, the dividend
                    unique case (step_reg[1:0])
                        2'd0:
                        begin
                            r_reg <= sum_reg - SUM_W'(prod_reg);
                            t_reg <= SQ_W'(prod_reg[31:0]) * SQ_W'(mean_reg[31:0]);
                            step_reg <= 7'd1;
                        end
                        2'd1:
                        begin
                            a_reg <= SQ_W'(mean_reg[31:0]) * SQ_W'(r_reg[31:0]);
                            step_reg <= 7'd2;
                        end
                        default:
                        begin
                            a_reg    <= sq_reg - t_reg - (a_reg << 1);
                            dq_reg   <= sq_reg - t_reg - (a_reg << 1);
                            drem_reg <= '0;
                            step_reg <= '0;
                            state_reg <= S_VAR_DIV;
                        end
                    endcase
                end
                S_VAR_FIX:
                begin
                    // remainder*n vs r*r, both fit in 64 bits
                    if (drem_reg[31:0] * nwide[31:0] >= r_reg[31:0] * r_reg[31:0])
                    begin
                        var_reg <= dq_reg;
                    end
                    else
                    begin
                        var_reg <= dq_reg - 1'b1;
                    end
                    sqrem_reg <= '0;
                    root_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_rem_sh >= sq_trial)
                    begin
                        sqrem_reg <= SQ_W'(sq_rem_sh - sq_trial);
                        root_reg  <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        sqrem_reg <= SQ_W'(sq_rem_sh);
                        root_reg  <= {root_reg[30:0], 1'b0};
                    end
                    var_reg  <= {var_reg[SQ_W-3:0], 2'b00};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 7'd31)
                    begin
                        state_reg <= S_SPIKE;
                    end
                end
                S_SPIKE:
                begin
                    prod_reg  <= SQ_W'(mult_reg) * SQ_W'(root_reg);
                    state_reg <= S_SPIKE2;
                end
                S_SPIKE2:
                begin
                    stats_flag_reg <= 1'b1;
                    if (root_reg != '0 &&
                        SQ_W'(x_reg) > SQ_W'(mean_reg) + (prod_reg >> 8))
                    begin
                        spike_flag_reg <= 1'b1;
                        if (spike_cnt_reg != CNT_MAX)
                        begin
                            spike_cnt_reg <= spike_cnt_reg + 1'b1;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // wait here only while the previous word is still stalled
                    if (out_free)
                    begin
                        o_mean_reg     <= stats_flag_reg ? mean_reg[23:0] : '0;
                        o_dev_reg      <= stats_flag_reg ? root_reg[23:0] : '0;
                        o_spike_reg    <= spike_flag_reg;
                        o_stats_reg    <= stats_flag_reg;
                        o_spikes_reg   <= spike_cnt_reg;
                        o_invalids_reg <= inv_cnt_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign window_mean      = o_mean_reg;
    assign window_deviation = o_dev_reg;
    assign spike_seen       = o_spike_reg;
    assign stats_valid      = o_stats_reg;
    assign spike_total      = o_spikes_reg;
    assign invalid_total    = o_invalids_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/wsd_checker.sv -----
// Port-level checks for the windowed spike detector, bound to the top level.
// No package dependencies.
`default_nettype none
module wsd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        spike_seen,
    input wire logic        stats_valid,
    input wire logic [23:0] window_deviation,
    input wire logic [15:0] spike_total
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");
    a_spike_needs_stats: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && spike_seen |-> stats_valid && window_deviation != 24'd0)
        else $error("spike without statistics");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while busy");
    a_spike_count: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> $stable(spike_total) || $past(in_stall))
        else $error("spike count moved while idle");
endmodule

bind windowed_spike_detector_unit wsd_checker u_wsd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .spike_seen(spike_seen),
    .stats_valid(stats_valid), .window_deviation(window_deviation),
    .spike_total(spike_total)
);
`default_nettype wire

// ----- tb/tb_windowed_spike_detector_unit.sv -----
// Self-checking testbench for windowed_spike_detector_unit: directed table, then
// random sample streams, each word checked against its table entry or an in-bench window model.
// Depends on wsd_pkg and the RTL of the detector.
`default_nettype none
module tb_windowed_spike_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import wsd_pkg::*;

    localparam int unsigned RING_DEPTH = 64;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned PEND_DEPTH = 64;
    localparam int unsigned ROW_SLOTS = 32;

    typedef struct {
        logic [23:0] mean;
        logic [23:0] deviation;
        logic        spike;
        logic        stats_ok;
        logic [15:0] spikes;
        logic [15:0] invalids;
    } stats_word_t;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_SET_LENGTH, ROW_SET_MULT} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [23:0] value;
        logic        invalid;
        logic        typed;
        stats_word_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [23:0] sample_value;
    logic        sample_invalid;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] window_mean;
    logic [23:0] window_deviation;
    logic        spike_seen;
    logic        stats_valid;
    logic [15:0] spike_total;
    logic [15:0] invalid_total;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // window model state
    logic [23:0] hist [RING_DEPTH];
    logic [5:0]  slot;
    logic [6:0]  fill;
    logic [63:0] sum_x;
    logic [63:0] sum_xx;
    logic [15:0] spike_cnt;
    logic [15:0] invalid_cnt;
    logic [6:0]  len_reg;
    logic [15:0] mult_reg;

    // expected words, ring of slots with running write and read counts
    stats_word_t pending_stats [PEND_DEPTH];
    int          pend_wr = 0;
    int          pend_rd = 0;
    stim_row_t   rows [ROW_SLOTS];
    int          row_count = 0;
    int          errors;
    bit          hold_req;
    bit          quiet_rx;

    windowed_spike_detector_unit dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void add_row(stim_row_t r);
        rows[row_count] = r;
        row_count++;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic stats_word_t predict_window(logic [23:0] x, logic inv);
        stats_word_t w;
        logic [6:0]   lim;
        logic [5:0]   old;
        logic [127:0] num;
        logic [63:0]  n;
        logic [63:0]  m;
        logic [63:0]  d;
        w = '{default: '0};
        if (inv)
        begin
            if (invalid_cnt != CNT_MAX)
                invalid_cnt++;
        end
        else
        begin
            lim = (len_reg == 0) ? 7'd1 : (len_reg > RING_DEPTH) ? 7'(RING_DEPTH) : len_reg;
            while (fill >= lim)
            begin
                old = 6'(slot - fill);
                sum_x -= hist[old];
                sum_xx -= 64'(hist[old]) * hist[old];
                fill--;
            end
            hist[slot] = x;
            slot++;
            fill++;
            sum_x += x;
            sum_xx += 64'(x) * x;
            if (fill >= MIN_SAMPLES)
            begin
                n = 64'(fill);
                m = sum_x / n;
                num = 128'(n) * sum_xx - 128'(sum_x) * sum_x;
                d = floor_root(64'(num / (128'(n) * n)));
                w.stats_ok = 1'b1;
                w.mean = m[23:0];
                w.deviation = d[23:0];
                if (d != 0 && 64'(x) > m + ((64'(mult_reg) * d) >> 8))
                begin
                    w.spike = 1'b1;
                    if (spike_cnt != CNT_MAX)
                        spike_cnt++;
                end
            end
        end
        w.spikes = spike_cnt;
        w.invalids = invalid_cnt;
        return w;
    endfunction

    // offers one word and waits until it is taken; the expectation is queued on acceptance
    task automatic send_word(logic [23:0] x, logic inv, logic typed, stats_word_t want);
        stats_word_t p;
        @(negedge clk);
        in_valid <= 1'b1;
        sample_value <= x;
        sample_invalid <= inv;
        do
            @(posedge clk);
        while (in_stall);
        p = predict_window(x, inv);
        pending_stats[pend_wr % PEND_DEPTH] = typed ? want : p;
        pend_wr++;
    endtask

    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        wait (pend_wr == pend_rd);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_LENGTH)
            len_reg = val[6:0];
        else
            mult_reg = val;
    endtask

    // receiver: changes its stall mode every so often, or holds off on request
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(20, 400);
                end
                left--;
                if (quiet_rx || mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    always @(posedge clk)
    begin
        stats_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pend_wr == pend_rd)
            begin
                $display("%t: unexpected word mean=%h dev=%h", $realtime, window_mean,
                         window_deviation);
                errors++;
            end
            else
            begin
                e = pending_stats[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (window_mean !== e.mean)
                begin
                    $display("%t: window_mean exp %h got %h", $realtime, e.mean, window_mean);
                    errors++;
                end
                if (window_deviation !== e.deviation)
                begin
                    $display("%t: window_deviation exp %h got %h", $realtime, e.deviation,
                             window_deviation);
                    errors++;
                end
                if (spike_seen !== e.spike)
                begin
                    $display("%t: spike_seen exp %b got %b", $realtime, e.spike, spike_seen);
                    errors++;
                end
                if (stats_valid !== e.stats_ok)
                begin
                    $display("%t: stats_valid exp %b got %b", $realtime, e.stats_ok,
                             stats_valid);
                    errors++;
                end
                if (spike_total !== e.spikes)
                begin
                    $display("%t: spike_total exp %0d got %0d", $realtime, e.spikes,
                             spike_total);
                    errors++;
                end
                if (invalid_total !== e.invalids)
                begin
                    $display("%t: invalid_total exp %0d got %0d", $realtime, e.invalids,
                             invalid_total);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("windowed_spike_detector_unit verification failed");
        $finish;
    end

    initial
    begin
        stats_word_t none;
        logic [23:0] base;
        logic [23:0] x;
        int          noise;
        int          sent;
        int          burst;
        int          pick;
        none = '{default: '0};
        errors = 0;
        hold_req = 1'b0;
        quiet_rx = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_value = '0;
        sample_invalid = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WINDOW_LENGTH;
        cfg_data = '0;
        foreach (hist[i])
            hist[i] = '0;
        slot = '0;
        fill = '0;
        sum_x = '0;
        sum_xx = '0;
        spike_cnt = '0;
        invalid_cnt = '0;
        len_reg = 7'd64;
        mult_reg = 16'd768;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // early rows: below five samples only the counters move, then statistics start
        add_row('{ROW_SAMPLE, 24'h000000, 1'b0, 1'b1, '{0, 0, 0, 0, 0, 0}});
        add_row('{ROW_SAMPLE, 24'hFFFFFF, 1'b1, 1'b1, '{0, 0, 0, 0, 0, 1}});
        add_row('{ROW_SAMPLE, 24'hFFFFFF, 1'b0, 1'b1, '{0, 0, 0, 0, 0, 1}});
        add_row('{ROW_SAMPLE, 24'h000000, 1'b0, 1'b1, '{0, 0, 0, 0, 0, 1}});
        add_row('{ROW_SAMPLE, 24'h123456, 1'b0, 1'b1, '{0, 0, 0, 0, 0, 1}});
        add_row('{ROW_SAMPLE, 24'h654321, 1'b0, 1'b0, none});
        add_row('{ROW_SAMPLE, 24'hFFFFFF, 1'b0, 1'b0, none});
        add_row('{ROW_SAMPLE, 24'h000001, 1'b1, 1'b0, none});
        add_row('{ROW_SAMPLE, 24'hFFFFFF, 1'b0, 1'b0, none});
        // short window, zero multiplier: flat data gives zero deviation, no spike
        add_row('{ROW_SET_LENGTH, 24'd5, 1'b0, 1'b0, none});
        add_row('{ROW_SET_MULT, 24'd0, 1'b0, 1'b0, none});
        for (int i = 0; i < 5; i++)
            add_row('{ROW_SAMPLE, 24'h100000, 1'b0, 1'b0, none});
        add_row('{ROW_SAMPLE, 24'h100001, 1'b0, 1'b0, none});
        add_row('{ROW_SET_MULT, 24'hFFFF, 1'b0, 1'b0, none});
        add_row('{ROW_SAMPLE, 24'hFFFFFF, 1'b0, 1'b0, none});
        // shrink while full drops several oldest words at once
        add_row('{ROW_SET_LENGTH, 24'd0, 1'b0, 1'b0, none});
        add_row('{ROW_SAMPLE, 24'h00ABCD, 1'b0, 1'b0, none});
        add_row('{ROW_SET_LENGTH, 24'd127, 1'b0, 1'b0, none});
        add_row('{ROW_SET_MULT, 24'd768, 1'b0, 1'b0, none});
        for (int i = 0; i < 5; i++)
            add_row('{ROW_SAMPLE, 24'(i * 24'h333333), 1'b0, 1'b0, none});

        for (int i = 0; i < row_count; i++)
        begin
            case (rows[i].kind)
                ROW_SAMPLE:
                    send_word(rows[i].value, rows[i].invalid, rows[i].typed, rows[i].want);
                ROW_SET_LENGTH:
                begin
                    wait_drained();
                    write_reg(CFG_WINDOW_LENGTH, rows[i].value[15:0]);
                end
                default:
                begin
                    wait_drained();
                    write_reg(CFG_SPIKE_MULT, rows[i].value[15:0]);
                end
            endcase
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            pick = $urandom_range(0, 5);
            write_reg(CFG_WINDOW_LENGTH, (pick == 0) ? 16'd1 : (pick == 1) ? 16'd127 :
                      (pick == 2) ? 16'd64 : 16'($urandom_range(0, 70)));
            pick = $urandom_range(0, 5);
            write_reg(CFG_SPIKE_MULT, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                      16'($urandom_range(64, 1024)));
            base = 24'($urandom);
            noise = 1 << $urandom_range(0, 20);
            if (ph == 3)
                hold_req = 1'b1;
            sent = 0;
            while (sent < 47)
            begin
                burst = $urandom_range(1, 10);
                for (int k = 0; k < burst && sent < 47; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10)
                        send_word(24'($urandom), 1'b1, 1'b0, none);
                    else if (pick < 20)
                        send_word(24'($urandom), 1'b0, 1'b0, none);
                    else
                    begin
                        x = (pick < 28) ? base + 24'($urandom_range(0, noise * 16))
                                        : base + 24'($urandom_range(0, noise));
                        send_word(x, 1'b0, 1'b0, none);
                    end
                    sent++;
                end
                if (ph != 3 && $urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 40));
            end
        end

        idle_cycles(1);
        wait (pend_wr == pend_rd);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("windowed_spike_detector_unit verification clean");
        else
            $display("windowed_spike_detector_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- windowed_spike_detector_unit.f -----
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_ram.sv
hw/rtl/windowed_spike_detector_unit.sv
hw/rtl/wsd_checker.sv
tb/tb_windowed_spike_detector_unit.sv
